// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the matcher RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define BPNFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define BPNFA_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BPNFA_ASSERT(lbl, clk, rstn, prop, msg)
`define BPNFA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/bpnfa_pkg.sv -----
// Shared types and constants for the bit-parallel NFA matcher.
// No dependencies; imported by every RTL file except assert_macros.svh.
package bpnfa_pkg;

  localparam int unsigned IDX_W  = 6;   // node index field
  localparam int unsigned CHAR_W = 8;   // character / text byte
  localparam int unsigned TGT_W  = 64;  // epsilon target mask
  localparam int unsigned POS_W  = 32;  // byte counter
  localparam int unsigned CFG_W  = 7;   // node_count register

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] NODE_COUNT_MIN = 7'd2;

  // node_type codes (type 3 behaves as final)
  localparam logic [1:0] NODE_CHAR  = 2'd0;
  localparam logic [1:0] NODE_EPS   = 2'd1;
  localparam logic [1:0] NODE_FINAL = 2'd2;

  // kind codes
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [1:0]       kind;
    logic [CHAR_W-1:0] chr;
    logic [TGT_W-1:0] targets;
  } node_wr_t;

  typedef struct packed {
    logic in_valid;
    logic in_text;
    logic tail_valid;
    logic out_free;
  } ctrl_stat_t;

  typedef struct packed {
    logic in_ready;
    logic launch;
    logic node_wr;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ----- rtl/bpnfa_in_if.sv -----
// Input channel of the matcher: valid/ready plus one item's fields.
// Depends on bpnfa_pkg for field widths.
interface bpnfa_in_if import bpnfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [IDX_W-1:0]  node_index;
  logic [1:0]        node_type;
  logic [CHAR_W-1:0] node_char;
  logic [TGT_W-1:0]  epsilon_targets;
  logic [CHAR_W-1:0] text_byte;

  modport source (
    output valid, kind, node_index, node_type, node_char, epsilon_targets, text_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, node_type, node_char, epsilon_targets, text_byte,
    output ready
  );
endinterface

// ----- rtl/bpnfa_out_if.sv -----
// Result channel of the matcher: valid/ready plus match flag and position.
// Depends on bpnfa_pkg for field widths.
interface bpnfa_out_if import bpnfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             match;
  logic [POS_W-1:0] position;

  modport source (
    output valid, match, position,
    input  ready
  );
  modport sink (
    input  valid, match, position,
    output ready
  );
endinterface

// ----- rtl/bpnfa_cell.sv -----
// One NFA node cell: stores the node and applies its epsilon step to the
// active-set word passing through. Depends on bpnfa_pkg.
module bpnfa_cell import bpnfa_pkg::*; #(
  parameter int unsigned N   = 64,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  node_wr_t          wr_i,
  input  logic              en_i,
  input  logic [CHAR_W-1:0] byte_i,
  input  logic              v_i,
  input  logic [N-1:0]      s_i,
  output logic              v_o,
  output logic [N-1:0]      s_o,
  output logic              hit_o,
  output logic              nonjump_o
);

  localparam logic [N-1:0]     SELF      = {{(N-1){1'b0}}, 1'b1} << IDX;
  localparam logic [TGT_W-1:0] BIT_ABOVE =
    (IDX + 1 < TGT_W) ? ({{(TGT_W-1){1'b0}}, 1'b1} << (IDX + 1)) : '0;

  logic [1:0]        kind_q;
  logic [CHAR_W-1:0] char_q;
  logic [TGT_W-1:0]  tgt_q;
  logic              v_q;
  logic [N-1:0]      s_q, s_d;
  logic              wr_hit, eps, fire;

  assign wr_hit = wr_i.en && (wr_i.idx == IDX_W'(IDX));
  assign eps    = (kind_q == NODE_EPS) && (|tgt_q);
  assign fire   = en_i && s_i[IDX] && eps;

  // clear own bit, then set targets (a self-target sets it back)
  assign s_d = fire ? ((s_i & ~SELF) | tgt_q[N-1:0]) : s_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= NODE_FINAL;
      v_q    <= 1'b0;
    end else begin
      v_q <= v_i;
      if (wr_hit) begin
        kind_q <= wr_i.kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (wr_hit) begin
      char_q <= wr_i.chr;
      tgt_q  <= wr_i.targets;
    end
  end

  assign v_o       = v_q;
  assign s_o       = s_q;
  assign hit_o     = (kind_q == NODE_CHAR) && (char_q == byte_i);
  assign nonjump_o = !eps || (tgt_q == BIT_ABOVE);

endmodule

// ----- rtl/bpnfa_ctrl.sv -----
// Item sequencer of the matcher: idle, epsilon walk, result hand-off.
// Depends on bpnfa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bpnfa_ctrl import bpnfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = stat_i.in_text ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (stat_i.tail_valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.launch   = stat_i.in_valid && stat_i.in_text;
        cmd_o.node_wr  = stat_i.in_valid && !stat_i.in_text;
      end
      ST_WALK: begin
        cmd_o.finish = stat_i.tail_valid;
      end
      ST_DONE: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  `BPNFA_NEVER(a_tail_outside_walk, clk_i, rst_ni, stat_i.tail_valid && (state_q != ST_WALK), "word left chain outside walk")
  `BPNFA_ASSERT(a_walk_exit, clk_i, rst_ni, (state_q == ST_WALK) |=> ((state_q == ST_WALK) || (state_q == ST_DONE)), "walk left to wrong state")
  `BPNFA_ASSERT(a_done_holds, clk_i, rst_ni, ((state_q == ST_DONE) && !stat_i.out_free) |=> (state_q == ST_DONE), "result dropped while output busy")

endmodule

// ----- rtl/bit_parallel_nfa_matcher.sv -----
// Top level of the bit-parallel NFA matcher: node cell chain, masks, output.
// Depends on bpnfa_pkg, bpnfa_in_if, bpnfa_out_if, bpnfa_cell, bpnfa_ctrl.
//
// The matcher runs a shift-and style NFA with epsilon nodes over a byte
// stream. A node-write beat loads one node (type, character, epsilon target
// mask) into its cell and returns a result with the match flag cleared; a
// text beat advances the active set and returns the match flag for the last
// node in use plus the saturating count of text bytes seen. Each node lives
// in its own cell, and the cells form a chain: the active-set word enters
// cell 0 and moves one cell per clock, each cell applying its own epsilon
// step, so the epsilon pass runs in ascending node order. A text beat passes
// through every cell of the chain, then the final masking and the output
// load. The result sits in an output register, so the next beat is accepted
// while an earlier result still waits on out_o.ready. Write node_count only
// while the block is idle: the cells read it throughout a walk. Values below
// 2 act as 2 and above MAX_NODES as MAX_NODES.
// The node tables need no clearing pass: node types reset to final, and the
// character and target entries are only read once a node has been written.
`include "assert_macros.svh"
module bit_parallel_nfa_matcher import bpnfa_pkg::*; #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bpnfa_in_if.sink         in_i,
  bpnfa_out_if.source      out_o
);

  localparam int unsigned N     = MAX_NODES;
  localparam int unsigned CNT_W = $clog2(N + 1);
  localparam int unsigned LST_W = $clog2(N);
  localparam logic [CFG_W-1:0] NODE_COUNT_MAX = CFG_W'(N);

  ctrl_stat_t stat;
  ctrl_cmd_t  cmd;

  logic [CFG_W-1:0]  node_count_q;
  logic [CFG_W-1:0]  n_clamp;
  logic [CNT_W-1:0]  n_use;
  logic [LST_W-1:0]  last_idx;
  logic [N-1:0]      en;

  logic [CHAR_W-1:0] byte_q;
  logic [N-1:0]      active_q, active_d;
  logic [POS_W-1:0]  count_q;
  logic              res_match_q;

  logic              out_valid_q;
  logic              out_match_q;
  logic [POS_W-1:0]  out_pos_q;

  node_wr_t          wr;
  logic [N-1:0]      s_chain [N];
  logic [N-1:0]      v_chain;
  logic [N-1:0]      hit, nonjump;
  logic [N-1:0]      byte_mask, nj_mask, shifted;

  // clamp the node count into the supported range
  always_comb begin
    if (node_count_q < NODE_COUNT_MIN) begin
      n_clamp = NODE_COUNT_MIN;
    end else if (node_count_q > NODE_COUNT_MAX) begin
      n_clamp = NODE_COUNT_MAX;
    end else begin
      n_clamp = node_count_q;
    end
  end

  assign n_use    = CNT_W'(n_clamp);
  assign last_idx = LST_W'(n_use - CNT_W'(1));

  // sequencer hookup
  assign stat.in_valid   = in_i.valid;
  assign stat.in_text    = (in_i.kind == KIND_TEXT);
  assign stat.tail_valid = v_chain[N-1];
  assign stat.out_free   = !out_valid_q || out_o.ready;

  bpnfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  assign in_i.ready = cmd.in_ready;

  // node write straight from the accepted beat
  assign wr.en      = cmd.node_wr;
  assign wr.idx     = in_i.node_index;
  assign wr.kind    = in_i.node_type;
  assign wr.chr     = in_i.node_char;
  assign wr.targets = in_i.epsilon_targets;

  // cell chain: cell 0 takes the active set with the start bit forced
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [N-1:0] s_in;
    logic         v_in;

    assign en[i] = (CNT_W'(i) < n_use);

    if (i == 0) begin : g_head
      assign s_in = active_q | {{(N-1){1'b0}}, 1'b1};
      assign v_in = cmd.launch;
    end else begin : g_link
      assign s_in = s_chain[i-1];
      assign v_in = v_chain[i-1];
    end

    bpnfa_cell #(
      .N   (N),
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (wr),
      .en_i      (en[i]),
      .byte_i    (byte_q),
      .v_i       (v_in),
      .s_i       (s_in),
      .v_o       (v_chain[i]),
      .s_o       (s_chain[i]),
      .hit_o     (hit[i]),
      .nonjump_o (nonjump[i])
    );
  end

  // node i drives bit i+1; the top node's bit falls off the word
  assign byte_mask = {hit[N-2:0] & en[N-2:0], 1'b1};
  assign nj_mask   = {nonjump[N-2:0] & en[N-2:0], 1'b1};
  assign shifted   = {s_chain[N-1][N-2:0], 1'b0};
  assign active_d  = shifted & byte_mask & nj_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      active_q     <= '0;
      count_q      <= '0;
      res_match_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd.node_wr) begin
        res_match_q <= 1'b0;
      end
      if (cmd.finish) begin
        active_q    <= active_d;
        res_match_q <= active_d[last_idx];
        if (count_q != '1) begin
          count_q <= count_q + POS_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: hold the byte for the walk, load the result beat
  always_ff @(posedge clk_i) begin
    if (cmd.launch) begin
      byte_q <= in_i.text_byte;
    end
    if (cmd.load_out) begin
      out_match_q <= res_match_q;
      out_pos_q   <= count_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.match    = out_match_q;
  assign out_o.position = out_pos_q;

  `BPNFA_ASSERT(a_single_word, clk_i, rst_ni, $countones(v_chain) <= 1, "more than one word in the chain")
  `BPNFA_NEVER(a_start_bit_clear, clk_i, rst_ni, active_q[0], "start bit left set in active set")
  `BPNFA_ASSERT(a_count_on_finish, clk_i, rst_ni, (count_q != $past(count_q)) |-> $past(cmd.finish), "byte count moved without a text beat")

endmodule
